// File: hdl/ntrg_pkg.sv
// ----------------------------------------------------------------------------
// ntrg_pkg: shared definitions for the nonzero tag random generator
// Command codes, word widths and the generator constants.
// ----------------------------------------------------------------------------
package ntrg_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = WORD_W / 2;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [HALF_W-1:0] half_type;

   // command codes
   localparam logic CMD_SEED = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // splitmix64 constants
   localparam word_type SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
   localparam word_type SM_MUL_A = 64'hbf58_476d_1ce4_e5b9;
   localparam word_type SM_MUL_B = 64'h94d0_49bb_1331_11eb;

   // loaded into the low word when seeding leaves both words zero
   localparam word_type SEED_FALLBACK = 64'h0123_4567_89ab_cdef;

   // shift amounts
   localparam int XS_SHL    = 23;
   localparam int XS_SHR_A  = 18;
   localparam int XS_SHR_B  = 5;
   localparam int SM_SHR_1  = 30;
   localparam int SM_SHR_2  = 27;
   localparam int SM_SHR_3  = 31;

endpackage

// File: hdl/ntrg_mul.sv
// ----------------------------------------------------------------------------
// ntrg_mul: iterative 64 x 64 multiplier, low half of the product
// One 32 x 32 multiplier, three partial products.
// ----------------------------------------------------------------------------
module ntrg_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ntrg_pkg::word_type op_a,
   input  ntrg_pkg::word_type op_b,
   output logic              done,
   output ntrg_pkg::word_type product
);

   ntrg_pkg::word_type a_ff, a_in;
   ntrg_pkg::word_type b_ff, b_in;
   ntrg_pkg::word_type acc_ff, acc_in;
   ntrg_pkg::word_type prod_ff, prod_in;
   logic [1:0]         step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   ntrg_pkg::half_type mul_x;
   ntrg_pkg::half_type mul_y;

   // step 0: aL*bL, step 1: aL*bH, step 2: aH*bL; accumulate one step behind
   always_comb begin
      mul_x   = (step_ff == 2'd2) ? a_ff[ntrg_pkg::WORD_W-1:ntrg_pkg::HALF_W]
                                  : a_ff[ntrg_pkg::HALF_W-1:0];
      mul_y   = (step_ff == 2'd1) ? b_ff[ntrg_pkg::WORD_W-1:ntrg_pkg::HALF_W]
                                  : b_ff[ntrg_pkg::HALF_W-1:0];
      prod_in = ntrg_pkg::WORD_W'(mul_x) * ntrg_pkg::WORD_W'(mul_y);

      acc_in = acc_ff;
      case (step_ff)
         2'd1:    acc_in = prod_ff;
         2'd2,
         2'd3:    acc_in = acc_ff + {prod_ff[ntrg_pkg::HALF_W-1:0],
                                     {ntrg_pkg::HALF_W{1'b0}}};
         default: acc_in = acc_ff;
      endcase
      if (!busy_ff) begin
         acc_in = acc_ff;
      end

      a_in    = start ? op_a : a_ff;
      b_in    = start ? op_b : b_ff;
      step_in = start ? 2'd0 : (busy_ff ? step_ff + 2'd1 : step_ff);
      done_in = busy_ff && (step_ff == 2'd3);
      busy_in = start || (busy_ff && (step_ff != 2'd3));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiply started while busy");

   a_done_free: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiply done while still busy");

endmodule

// File: hdl/nonzero_tag_random_generator.sv
// ----------------------------------------------------------------------------
// nonzero_tag_random_generator: xorshift128+ tag source, splitmix64 seeding
// Top level: command sequencer, generator words and result register.
// ----------------------------------------------------------------------------
// A seed item (command 0) loads the two generator words through splitmix64 and
// gives no result; a draw item (command 1) advances xorshift128+ and returns
// the sum of the two old words, stepping once more when that sum is zero.
// Input is taken only while the sequencer is idle (req_stall low). A seed
// runs four 64-bit multiplies through one shared 32 x 32 multiplier, each
// with three partial products plus issue and drain. A finished tag sits in
// the rsp_ register; the next item is accepted while it waits.
// ----------------------------------------------------------------------------
module nonzero_tag_random_generator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  ntrg_pkg::word_type  req_seed_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ntrg_pkg::word_type  rsp_generation
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_STARTA,   // issue (v ^ v>>30) * MUL_A
      S_WAITA,
      S_STARTB,   // issue (v ^ v>>27) * MUL_B
      S_WAITB,
      S_DRAW,     // one xorshift128+ step a cycle
      S_PUT       // tag ready, result register still occupied
   } state_type;

   state_type          state_ff, state_in;
   ntrg_pkg::word_type low_ff, low_in;
   ntrg_pkg::word_type high_ff, high_in;
   ntrg_pkg::word_type v_ff, v_in;        // splitmix working value
   logic               pass_ff, pass_in;  // 0: mixing seed, 1: mixing low word
   logic               retry_ff, retry_in;
   ntrg_pkg::word_type tag_ff, tag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ntrg_pkg::word_type rsp_gen_ff, rsp_gen_in;

   logic               mul_start;
   ntrg_pkg::word_type mul_a;
   ntrg_pkg::word_type mul_b;
   logic               mul_done;
   ntrg_pkg::word_type mul_product;

   ntrg_pkg::word_type sum;
   ntrg_pkg::word_type xs_t;
   ntrg_pkg::word_type xs_high;
   ntrg_pkg::word_type mix_z;
   logic               slot_free;

   // shared multiplier
   ntrg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   assign mul_start = (state_ff == S_STARTA) || (state_ff == S_STARTB);
   assign mul_a     = (state_ff == S_STARTA) ? (v_ff ^ (v_ff >> ntrg_pkg::SM_SHR_1))
                                             : (v_ff ^ (v_ff >> ntrg_pkg::SM_SHR_2));
   assign mul_b     = (state_ff == S_STARTA) ? ntrg_pkg::SM_MUL_A : ntrg_pkg::SM_MUL_B;

   // xorshift128+ step on the current words
   assign sum     = low_ff + high_ff;
   assign xs_t    = low_ff ^ (low_ff << ntrg_pkg::XS_SHL);
   assign xs_high = xs_t ^ high_ff ^ (xs_t >> ntrg_pkg::XS_SHR_A)
                    ^ (high_ff >> ntrg_pkg::XS_SHR_B);

   // final splitmix fold
   assign mix_z = mul_product ^ (mul_product >> ntrg_pkg::SM_SHR_3);

   // result register can take a new item this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      v_in         = v_ff;
      pass_in      = pass_ff;
      retry_in     = retry_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_gen_in   = rsp_gen_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == ntrg_pkg::CMD_DRAW) begin
                  retry_in = 1'b0;
                  state_in = S_DRAW;
               end else begin
                  v_in     = req_seed_value + ntrg_pkg::SM_GAMMA;
                  pass_in  = 1'b0;
                  state_in = S_STARTA;
               end
            end
         end
         S_STARTA: begin
            state_in = S_WAITA;
         end
         S_WAITA: begin
            if (mul_done) begin
               v_in     = mul_product;
               state_in = S_STARTB;
            end
         end
         S_STARTB: begin
            state_in = S_WAITB;
         end
         S_WAITB: begin
            if (mul_done) begin
               if (!pass_ff) begin
                  // low word done, mix it again for the high word
                  low_in   = mix_z;
                  v_in     = mix_z + ntrg_pkg::SM_GAMMA;
                  pass_in  = 1'b1;
                  state_in = S_STARTA;
               end else begin
                  high_in = mix_z;
                  if ((low_ff == '0) && (mix_z == '0)) begin
                     low_in = ntrg_pkg::SEED_FALLBACK;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         S_DRAW: begin
            low_in  = high_ff;
            high_in = xs_high;
            if ((sum == '0) && !retry_ff) begin
               retry_in = 1'b1;   // zero tag: one more step, no further check
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_gen_in   = sum;
               state_in     = S_IDLE;
            end else begin
               tag_in   = sum;
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_gen_in   = tag_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_ff       <= '0;
         high_ff      <= '0;
         pass_ff      <= 1'b0;
         retry_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         pass_ff      <= pass_in;
         retry_ff     <= retry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff       <= v_in;
      tag_ff     <= tag_in;
      rsp_gen_ff <= rsp_gen_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_generation = rsp_gen_ff;

   // a seed item never produces a result
   a_seed_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_command == ntrg_pkg::CMD_SEED))
      |=> !$rose(rsp_valid))
      else $error("seed item produced a result");

   // multiplier completions only land where the sequencer waits for them
   a_mul_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> ((state_ff == S_WAITA) || (state_ff == S_WAITB)))
      else $error("unexpected multiply completion");

   // seeding never leaves the generator all zero
   a_seed_nonzero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WAITB) && mul_done && pass_ff)
      |=> ((low_ff != '0) || (high_ff != '0)))
      else $error("seed left both words zero");

   // a parked tag means the result register is occupied
   a_put_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |-> rsp_valid)
      else $error("tag parked with result register empty");

endmodule
